FILE: rtl/core/ctc_pkg.sv
package ctc_pkg;

  // coordinate and intermediate widths
  localparam int CW        = 32;          // coordinate word
  localparam int DW        = CW + 1;      // coordinate difference
  localparam int PW        = 2 * DW;      // product of two differences
  localparam int LW        = PW + 1;      // squared length, sum of squares
  localparam int MW        = PW + 1;      // magnitude of dot and cross
  localparam int GW        = 16;          // gain register
  localparam int GAIN_FRAC = 8;           // gain fraction bits
  localparam int GDW       = GW + DW;     // gain times difference
  localparam int LB        = 34;          // low limb of a dot or cross magnitude
  localparam int GB        = 25;          // low limb of a gain product

  // divider and square root widths
  localparam int NW  = 136;               // dividend
  localparam int DNW = LW + GAIN_FRAC;    // divisor
  localparam int QW  = 70;                // quotient bits, one per stage
  localparam int XW  = DNW + QW;          // aligned divisor
  localparam int RW  = QW / 2;            // root bits, one per stage
  localparam int SRW = RW + 3;            // root remainder
  localparam int QRW = 44;                // rounded quotient
  localparam int RSW = QRW + 2;           // signed offset and sum

  // pipeline depth: six front stages, divider, root, output register
  localparam int PRE = 6;
  localparam int TOT = PRE + QW + RW + 1;

  // register map
  localparam int AW = 3;
  localparam logic [AW-3:0] REG_GAIN = 1'b0;
  localparam logic [GW-1:0] GAIN_RESET = 16'd768;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic        [CW-1:0] deviation;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic                 degenerate;
  } result_t;

  typedef logic [NW-1:0]  num_t;
  typedef logic [DNW-1:0] den_t;
  typedef logic [QW-1:0]  quo_t;
  typedef logic [XW-1:0]  ext_t;
  typedef logic [RW-1:0]  root_t;
  typedef logic [SRW-1:0] srem_t;

  // base coordinates and result signs carried beside the arithmetic
  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic          degen;
    logic          neg_fx;
    logic          neg_fy;
    logic          neg_tx;
    logic          neg_ty;
  } side_t;

  // finished coordinates waiting for the root
  typedef struct packed {
    logic [CW-1:0] foot_x;
    logic [CW-1:0] foot_y;
    logic [CW-1:0] target_x;
    logic [CW-1:0] target_y;
    logic          degen;
  } res_t;

  // magnitude of a two's complement difference
  function automatic logic [DW-1:0] mag_diff(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // clamp a wide signed sum to the coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [RSW-1:0] v);
    logic [CW-1:0] r;
    if (&v[RSW-1:CW-1] || ~|v[RSW-1:CW-1]) begin
      r = v[CW-1:0];
    end else if (v[RSW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // round quotient to nearest, ties away from zero, apply sign, add base
  function automatic logic [CW-1:0] fix_round(input logic [CW-1:0] base,
                                              input quo_t q, input den_t r,
                                              input den_t d, input logic neg);
    logic           up;
    logic [QRW-1:0] qr;
    logic [RSW-1:0] off;
    logic [RSW-1:0] sum;
    up  = {r, 1'b0} >= {1'b0, d};
    qr  = q[QRW-1:0] + {{(QRW-1){1'b0}}, up};
    off = neg ? (~{2'b00, qr} + 1'b1) : {2'b00, qr};
    sum = {{(RSW-CW){base[CW-1]}}, base} + off;
    return sat_coord(sum);
  endfunction

endpackage

FILE: rtl/core/ctc_div.sv
// pipelined restoring divider, one quotient bit per stage
module ctc_div (
  input  logic           clk,
  input  logic           en,
  input  ctc_pkg::num_t  num,
  input  ctc_pkg::den_t  den,
  output ctc_pkg::quo_t  quo,
  output ctc_pkg::den_t  rem,
  output ctc_pkg::den_t  den_out
);

  ctc_pkg::num_t r [ctc_pkg::QW];
  ctc_pkg::den_t d [ctc_pkg::QW];
  ctc_pkg::quo_t q [ctc_pkg::QW];

  for (genvar k = 0; k < ctc_pkg::QW; k++) begin : g_stage
    ctc_pkg::num_t r_in;
    ctc_pkg::den_t d_in;
    ctc_pkg::quo_t q_in;
    ctc_pkg::ext_t sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r[k-1];
      assign d_in = d[k-1];
      assign q_in = q[k-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign sh = ctc_pkg::ext_t'(d_in) << (ctc_pkg::QW - 1 - k);
    assign ge = ctc_pkg::ext_t'(r_in) >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        r[k] <= ge ? (r_in - sh[ctc_pkg::NW-1:0]) : r_in;
        d[k] <= d_in;
        q[k] <= {q_in[ctc_pkg::QW-2:0], ge};
      end
    end
  end

  assign quo     = q[ctc_pkg::QW-1];
  assign rem     = r[ctc_pkg::QW-1][ctc_pkg::DNW-1:0];
  assign den_out = d[ctc_pkg::QW-1];

endmodule

FILE: rtl/core/ctc_sqrt.sv
// pipelined integer square root, one root bit per stage
module ctc_sqrt (
  input  logic           clk,
  input  logic           en,
  input  ctc_pkg::quo_t  x,
  output ctc_pkg::root_t root
);

  ctc_pkg::quo_t  xs [ctc_pkg::RW];
  ctc_pkg::srem_t rs [ctc_pkg::RW];
  ctc_pkg::root_t qs [ctc_pkg::RW];

  for (genvar k = 0; k < ctc_pkg::RW; k++) begin : g_stage
    localparam int B = ctc_pkg::RW - 1 - k;
    ctc_pkg::quo_t  x_in;
    ctc_pkg::srem_t r_in;
    ctc_pkg::root_t q_in;
    ctc_pkg::srem_t cur;
    ctc_pkg::srem_t trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign x_in = x;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rs[k-1];
      assign q_in = qs[k-1];
    end

    // bring down the next bit pair and try root*4+1
    assign cur   = {r_in[ctc_pkg::RW:0], x_in[2*B+1 -: 2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= x_in;
        rs[k] <= ge ? (cur - trial) : cur;
        qs[k] <= {q_in[ctc_pkg::RW-2:0], ge};
      end
    end
  end

  assign root = qs[ctc_pkg::RW-1];

endmodule

FILE: rtl/core/cross_track_correction.sv
// pipeline: 6 front stages (differences, products, sums, signs, partial products,
//   numerators), 70 divider stages at one quotient bit each, 35 root stages, output register
// throughput: one item per cycle; a stalled result holds the whole pipeline
// reset: synchronous, clears all valid bits and sets the gain register to 3.0;
//   data registers are not reset
module cross_track_correction (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ctc_pkg::AW-1:0]   paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  ctc_pkg::item_t           item,
  output logic                     result_valid,
  input  logic                     result_ready,
  output ctc_pkg::result_t         result
);

  localparam int CW  = ctc_pkg::CW;
  localparam int DW  = ctc_pkg::DW;
  localparam int PW  = ctc_pkg::PW;
  localparam int LW  = ctc_pkg::LW;
  localparam int MW  = ctc_pkg::MW;
  localparam int GDW = ctc_pkg::GDW;
  localparam int LB  = ctc_pkg::LB;
  localparam int GB  = ctc_pkg::GB;
  localparam int QW  = ctc_pkg::QW;
  localparam int RW  = ctc_pkg::RW;
  localparam int TOT = ctc_pkg::TOT;

  // configuration register
  logic [ctc_pkg::GW-1:0] gain;
  logic                   gain_sel;

  assign pready   = 1'b1;
  assign gain_sel = paddr[ctc_pkg::AW-1:2] == ctc_pkg::REG_GAIN;
  assign prdata   = gain_sel ? {{(32-ctc_pkg::GW){1'b0}}, gain} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= ctc_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && gain_sel) begin
      gain <= pwdata[ctc_pkg::GW-1:0];
    end
  end

  // valid bits and global advance
  logic [TOT-1:0] vld;
  logic           adv;

  assign adv          = !vld[TOT-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], item_valid};
    end
  end

  // stage 1: differences to sign and magnitude
  logic [DW-1:0] dxs, dys, pxs, pys;
  assign dxs = {item.end_x[CW-1], item.end_x} - {item.start_x[CW-1], item.start_x};
  assign dys = {item.end_y[CW-1], item.end_y} - {item.start_y[CW-1], item.start_y};
  assign pxs = {item.pos_x[CW-1], item.pos_x} - {item.start_x[CW-1], item.start_x};
  assign pys = {item.pos_y[CW-1], item.pos_y} - {item.start_y[CW-1], item.start_y};

  logic [DW-1:0]   s1_mdx, s1_mdy, s1_mpx, s1_mpy;
  logic            s1_sdx, s1_sdy, s1_spx, s1_spy;
  ctc_pkg::side_t  s1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mdx <= ctc_pkg::mag_diff(dxs);
      s1_mdy <= ctc_pkg::mag_diff(dys);
      s1_mpx <= ctc_pkg::mag_diff(pxs);
      s1_mpy <= ctc_pkg::mag_diff(pys);
      s1_sdx <= dxs[DW-1];
      s1_sdy <= dys[DW-1];
      s1_spx <= pxs[DW-1];
      s1_spy <= pys[DW-1];
      s1_side.sx     <= item.start_x;
      s1_side.sy     <= item.start_y;
      s1_side.ex     <= item.end_x;
      s1_side.ey     <= item.end_y;
      s1_side.degen  <= (item.start_x == item.end_x) && (item.start_y == item.end_y);
      s1_side.neg_fx <= 1'b0;
      s1_side.neg_fy <= 1'b0;
      s1_side.neg_tx <= 1'b0;
      s1_side.neg_ty <= 1'b0;
    end
  end

  // stage 2: magnitude products and gain products
  logic [PW-1:0]  s2_xx, s2_yy, s2_xpx, s2_ypy, s2_xpy, s2_ypx, s2_pxx, s2_pyy;
  logic           s2_n_xpx, s2_n_ypy, s2_n_xpy, s2_n_ypx;
  logic [GDW-1:0] s2_gdx, s2_gdy;
  logic [DW-1:0]  s2_mdx, s2_mdy;
  logic           s2_sdx, s2_sdy;
  ctc_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_xx    <= s1_mdx * s1_mdx;
      s2_yy    <= s1_mdy * s1_mdy;
      s2_xpx   <= s1_mdx * s1_mpx;
      s2_ypy   <= s1_mdy * s1_mpy;
      s2_xpy   <= s1_mdx * s1_mpy;
      s2_ypx   <= s1_mdy * s1_mpx;
      s2_pxx   <= s1_mpx * s1_mpx;
      s2_pyy   <= s1_mpy * s1_mpy;
      s2_n_xpx <= s1_sdx ^ s1_spx;
      s2_n_ypy <= s1_sdy ^ s1_spy;
      s2_n_xpy <= s1_sdx ^ s1_spy;
      s2_n_ypx <= s1_sdy ^ s1_spx;
      s2_gdx   <= gain * s1_mdx;
      s2_gdy   <= gain * s1_mdy;
      s2_mdx   <= s1_mdx;
      s2_mdy   <= s1_mdy;
      s2_sdx   <= s1_sdx;
      s2_sdy   <= s1_sdy;
      s2_side  <= s1_side;
    end
  end

  // stage 3: squared length, dot, cross, squared offset
  logic [MW:0] t_xpx, t_ypy, t_xpy, t_ypx;
  assign t_xpx = s2_n_xpx ? (~{2'b00, s2_xpx} + 1'b1) : {2'b00, s2_xpx};
  assign t_ypy = s2_n_ypy ? (~{2'b00, s2_ypy} + 1'b1) : {2'b00, s2_ypy};
  assign t_xpy = s2_n_xpy ? (~{2'b00, s2_xpy} + 1'b1) : {2'b00, s2_xpy};
  assign t_ypx = s2_n_ypx ? (~{2'b00, s2_ypx} + 1'b1) : {2'b00, s2_ypx};

  logic [LW-1:0]  s3_l2, s3_qq;
  logic [MW:0]    s3_dot, s3_cr;
  logic [GDW-1:0] s3_gdx, s3_gdy;
  logic [DW-1:0]  s3_mdx, s3_mdy;
  logic           s3_sdx, s3_sdy;
  ctc_pkg::side_t s3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_l2   <= {1'b0, s2_xx} + {1'b0, s2_yy};
      s3_qq   <= {1'b0, s2_pxx} + {1'b0, s2_pyy};
      s3_dot  <= t_xpx + t_ypy;
      s3_cr   <= t_xpy - t_ypx;
      s3_gdx  <= s2_gdx;
      s3_gdy  <= s2_gdy;
      s3_mdx  <= s2_mdx;
      s3_mdy  <= s2_mdy;
      s3_sdx  <= s2_sdx;
      s3_sdy  <= s2_sdy;
      s3_side <= s2_side;
    end
  end

  // stage 4: dot and cross to sign and magnitude
  logic [MW:0] dot_neg, cr_neg;
  assign dot_neg = ~s3_dot + 1'b1;
  assign cr_neg  = ~s3_cr + 1'b1;

  logic [MW-1:0]  s4_adot, s4_acr;
  logic           s4_ndot, s4_ncr;
  logic [LW-1:0]  s4_l2, s4_qq;
  logic [GDW-1:0] s4_gdx, s4_gdy;
  logic [DW-1:0]  s4_mdx, s4_mdy;
  logic           s4_sdx, s4_sdy;
  ctc_pkg::side_t s4_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_adot <= s3_dot[MW] ? dot_neg[MW-1:0] : s3_dot[MW-1:0];
      s4_acr  <= s3_cr[MW] ? cr_neg[MW-1:0] : s3_cr[MW-1:0];
      s4_ndot <= s3_dot[MW];
      s4_ncr  <= s3_cr[MW];
      s4_l2   <= s3_l2;
      s4_qq   <= s3_qq;
      s4_gdx  <= s3_gdx;
      s4_gdy  <= s3_gdy;
      s4_mdx  <= s3_mdx;
      s4_mdy  <= s3_mdy;
      s4_sdx  <= s3_sdx;
      s4_sdy  <= s3_sdy;
      s4_side <= s3_side;
    end
  end

  // stage 5: partial products of the wide numerators
  logic [LB+DW-1:0]               s5_fx0, s5_fy0;
  logic [MW-LB+DW-1:0]            s5_fx1, s5_fy1;
  logic [LB+GB-1:0]               s5_tx00, s5_ty00;
  logic [LB+GDW-GB-1:0]           s5_tx01, s5_ty01;
  logic [MW-LB+GB-1:0]            s5_tx10, s5_ty10;
  logic [MW-LB+GDW-GB-1:0]        s5_tx11, s5_ty11;
  logic [2*LB-1:0]                s5_c00;
  logic [MW-1:0]                  s5_c01;
  logic [2*(MW-LB)-1:0]           s5_c11;
  logic [LW-1:0]                  s5_l2, s5_qq;
  ctc_pkg::side_t                 s5_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_fx0  <= s4_adot[LB-1:0] * s4_mdx;
      s5_fx1  <= s4_adot[MW-1:LB] * s4_mdx;
      s5_fy0  <= s4_adot[LB-1:0] * s4_mdy;
      s5_fy1  <= s4_adot[MW-1:LB] * s4_mdy;
      s5_tx00 <= s4_acr[LB-1:0] * s4_gdy[GB-1:0];
      s5_tx01 <= s4_acr[LB-1:0] * s4_gdy[GDW-1:GB];
      s5_tx10 <= s4_acr[MW-1:LB] * s4_gdy[GB-1:0];
      s5_tx11 <= s4_acr[MW-1:LB] * s4_gdy[GDW-1:GB];
      s5_ty00 <= s4_acr[LB-1:0] * s4_gdx[GB-1:0];
      s5_ty01 <= s4_acr[LB-1:0] * s4_gdx[GDW-1:GB];
      s5_ty10 <= s4_acr[MW-1:LB] * s4_gdx[GB-1:0];
      s5_ty11 <= s4_acr[MW-1:LB] * s4_gdx[GDW-1:GB];
      s5_c00  <= s4_acr[LB-1:0] * s4_acr[LB-1:0];
      s5_c01  <= s4_acr[LB-1:0] * s4_acr[MW-1:LB];
      s5_c11  <= s4_acr[MW-1:LB] * s4_acr[MW-1:LB];
      s5_l2   <= s4_l2;
      s5_qq   <= s4_qq;
      s5_side.sx    <= s4_side.sx;
      s5_side.sy    <= s4_side.sy;
      s5_side.ex    <= s4_side.ex;
      s5_side.ey    <= s4_side.ey;
      s5_side.degen <= s4_side.degen;
      // normal flip is folded into the target signs
      s5_side.neg_fx <= s4_ndot ^ s4_sdx;
      s5_side.neg_fy <= s4_ndot ^ s4_sdy;
      s5_side.neg_tx <= s4_ncr ^ s4_sdy;
      s5_side.neg_ty <= ~(s4_ncr ^ s4_sdx);
    end
  end

  // stage 6: numerators and divisors
  ctc_pkg::num_t  c2;
  assign c2 = ctc_pkg::num_t'(s5_c00) + (ctc_pkg::num_t'(s5_c01) << (LB + 1))
            + (ctc_pkg::num_t'(s5_c11) << (2 * LB));

  ctc_pkg::num_t  s6_nfx, s6_nfy, s6_ntx, s6_nty, s6_ndev;
  ctc_pkg::den_t  s6_dfoot, s6_dtgt, s6_ddev;
  ctc_pkg::side_t s6_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_nfx   <= ctc_pkg::num_t'(s5_fx0) + (ctc_pkg::num_t'(s5_fx1) << LB);
      s6_nfy   <= ctc_pkg::num_t'(s5_fy0) + (ctc_pkg::num_t'(s5_fy1) << LB);
      s6_ntx   <= ctc_pkg::num_t'(s5_tx00) + (ctc_pkg::num_t'(s5_tx01) << GB)
                + (ctc_pkg::num_t'(s5_tx10) << LB) + (ctc_pkg::num_t'(s5_tx11) << (LB + GB));
      s6_nty   <= ctc_pkg::num_t'(s5_ty00) + (ctc_pkg::num_t'(s5_ty01) << GB)
                + (ctc_pkg::num_t'(s5_ty10) << LB) + (ctc_pkg::num_t'(s5_ty11) << (LB + GB));
      // zero-length segment: root of four times the squared offset
      s6_ndev  <= s5_side.degen ? (ctc_pkg::num_t'(s5_qq) << 2) : (c2 << 2);
      s6_ddev  <= s5_side.degen ? ctc_pkg::den_t'(1) : ctc_pkg::den_t'(s5_l2);
      s6_dfoot <= ctc_pkg::den_t'(s5_l2);
      s6_dtgt  <= ctc_pkg::den_t'(s5_l2) << ctc_pkg::GAIN_FRAC;
      s6_side  <= s5_side;
    end
  end

  // dividers
  ctc_pkg::quo_t q_fx, q_fy, q_tx, q_ty, q_dev;
  ctc_pkg::den_t r_fx, r_fy, r_tx, r_ty, r_dev;
  ctc_pkg::den_t d_fx, d_fy, d_tx, d_ty, d_dev;

  ctc_div u_div_fx (.clk, .en(adv), .num(s6_nfx), .den(s6_dfoot),
                    .quo(q_fx), .rem(r_fx), .den_out(d_fx));
  ctc_div u_div_fy (.clk, .en(adv), .num(s6_nfy), .den(s6_dfoot),
                    .quo(q_fy), .rem(r_fy), .den_out(d_fy));
  ctc_div u_div_tx (.clk, .en(adv), .num(s6_ntx), .den(s6_dtgt),
                    .quo(q_tx), .rem(r_tx), .den_out(d_tx));
  ctc_div u_div_ty (.clk, .en(adv), .num(s6_nty), .den(s6_dtgt),
                    .quo(q_ty), .rem(r_ty), .den_out(d_ty));
  ctc_div u_div_dev (.clk, .en(adv), .num(s6_ndev), .den(s6_ddev),
                     .quo(q_dev), .rem(r_dev), .den_out(d_dev));

  // side data travels beside the dividers
  ctc_pkg::side_t side_d [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= s6_side;
      for (int k = 1; k < QW; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // rounding, sign and base add; zero-length segment keeps start and end
  ctc_pkg::side_t sd;
  ctc_pkg::res_t  res_in;
  logic           dev_rem_nz;

  assign sd         = side_d[QW-1];
  assign dev_rem_nz = |r_dev && |d_dev;

  always_comb begin
    res_in.degen = sd.degen;
    if (sd.degen) begin
      res_in.foot_x   = sd.sx;
      res_in.foot_y   = sd.sy;
      res_in.target_x = sd.ex;
      res_in.target_y = sd.ey;
    end else begin
      res_in.foot_x   = ctc_pkg::fix_round(sd.sx, q_fx, r_fx, d_fx, sd.neg_fx);
      res_in.foot_y   = ctc_pkg::fix_round(sd.sy, q_fy, r_fy, d_fy, sd.neg_fy);
      res_in.target_x = ctc_pkg::fix_round(sd.ex, q_tx, r_tx, d_tx, sd.neg_tx);
      res_in.target_y = ctc_pkg::fix_round(sd.ey, q_ty, r_ty, d_ty, sd.neg_ty);
    end
  end

  // deviation root
  ctc_pkg::root_t root;
  ctc_sqrt u_sqrt (.clk, .en(adv), .x(q_dev), .root);

  // finished coordinates travel beside the root
  ctc_pkg::res_t res_d [RW];

  always_ff @(posedge clk) begin
    if (adv) begin
      res_d[0] <= res_in;
      for (int k = 1; k < RW; k++) begin
        res_d[k] <= res_d[k-1];
      end
    end
  end

  // output register: halve the root with rounding up, then clamp
  logic [RW-1:0] half;
  logic [CW-1:0] dev_sat;
  logic          unused_rem;

  assign half       = {1'b0, root[RW-1:1]} + {{(RW-1){1'b0}}, root[0]};
  assign dev_sat    = |half[RW-1:CW] ? '1 : half[CW-1:0];
  assign unused_rem = dev_rem_nz;

  always_ff @(posedge clk) begin
    if (adv) begin
      result.foot_x     <= res_d[RW-1].foot_x;
      result.foot_y     <= res_d[RW-1].foot_y;
      result.deviation  <= dev_sat;
      result.target_x   <= res_d[RW-1].target_x;
      result.target_y   <= res_d[RW-1].target_y;
      result.degenerate <= res_d[RW-1].degen | (unused_rem & 1'b0);
    end
  end

endmodule

FILE: rtl/core/ctc_checker.sv
module ctc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [ctc_pkg::AW-1:0] paddr,
  input logic [31:0]            pwdata,
  input logic [31:0]            prdata,
  input logic                   pready,
  input logic                   item_valid,
  input logic                   item_ready,
  input ctc_pkg::item_t         item,
  input logic                   result_valid,
  input logic                   result_ready,
  input ctc_pkg::result_t       result
);

  // a waiting result stays and holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // input side opens exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    item_ready == (!result_valid || result_ready))
    else $error("item_ready does not follow output stall");

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // gain write reads back on the next cycle
  a_gain_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[ctc_pkg::AW-1:2] == ctc_pkg::REG_GAIN)
    |=> (paddr[ctc_pkg::AW-1:2] != ctc_pkg::REG_GAIN)
        || (prdata[ctc_pkg::GW-1:0] == $past(pwdata[ctc_pkg::GW-1:0])))
    else $error("gain register readback mismatch");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind cross_track_correction ctc_checker u_ctc_checker (.*);

FILE: dv/cross_track_correction_tb.sv
`timescale 1ns / 1ps

module cross_track_correction_tb;

  typedef logic signed [255:0] wide_t;

  localparam int WATCHDOG  = 20000;
  localparam int DRAIN     = 160;
  localparam int N_RANDOM  = 380;
  localparam logic [ctc_pkg::AW-1:0] GAIN_ADDR = ctc_pkg::AW'(4 * ctc_pkg::REG_GAIN);

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ctc_pkg::AW-1:0]   paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     item_valid;
  logic                     item_ready;
  ctc_pkg::item_t           item;
  logic                     result_valid;
  logic                     result_ready;
  ctc_pkg::result_t         result;

  logic [ctc_pkg::GW-1:0]   gain_model;
  ctc_pkg::result_t         pending_results[$];
  int                       items_sent;
  int                       results_seen;
  int                       degen_seen;
  int                       errors;
  int                       idle_cycles;
  logic                     hold_off;
  int                       gains_used;

  cross_track_correction dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // integer square root, floor
  function automatic wide_t isqrt(input wide_t x);
    wide_t r;
    wide_t c;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic wide_t round_div(input wide_t n, input wide_t d);
    wide_t a;
    wide_t q;
    a = (n < 0) ? -n : n;
    q = (2 * a + d) / (2 * d);
    if (q > (wide_t'(1) <<< 62)) q = wide_t'(1) <<< 62;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [ctc_pkg::CW-1:0] clamp_coord(input wide_t v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[ctc_pkg::CW-1:0];
  endfunction

  // expected correction for one position fix
  function automatic ctc_pkg::result_t correct_track(input ctc_pkg::item_t it,
                                                     input logic [ctc_pkg::GW-1:0] g);
    ctc_pkg::result_t r;
    wide_t sx, sy, ex, ey, dx, dy, px, py, l2, dot, cr, m, dv, gw;
    sx = $signed(it.start_x);
    sy = $signed(it.start_y);
    ex = $signed(it.end_x);
    ey = $signed(it.end_y);
    dx = ex - sx;
    dy = ey - sy;
    px = $signed(it.pos_x) - sx;
    py = $signed(it.pos_y) - sy;
    l2 = dx * dx + dy * dy;
    gw = {240'd0, g};
    if (l2 == 0) begin
      m = isqrt(4 * (px * px + py * py));
      r.foot_x   = clamp_coord(sx);
      r.foot_y   = clamp_coord(sy);
      r.target_x = clamp_coord(ex);
      r.target_y = clamp_coord(ey);
      r.degenerate = 1'b1;
    end else begin
      dot = dx * px + dy * py;
      cr  = dx * py - dy * px;
      m = isqrt((4 * cr * cr) / l2);
      r.foot_x   = clamp_coord(sx + round_div(dot * dx, l2));
      r.foot_y   = clamp_coord(sy + round_div(dot * dy, l2));
      r.target_x = clamp_coord(ex + round_div(cr * dy * gw, 256 * l2));
      r.target_y = clamp_coord(ey + round_div(-(cr * dx * gw), 256 * l2));
      r.degenerate = 1'b0;
    end
    dv = (m >>> 1) + (m & 1);
    r.deviation = (dv > 64'shffffffff) ? 32'hffffffff : dv[ctc_pkg::CW-1:0];
    return r;
  endfunction

  // register write, setup then access
  task automatic write_gain(input logic [ctc_pkg::GW-1:0] g);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= {16'd0, g};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gain_model = g;
    gains_used++;
  endtask

  // wait for the pipeline to empty before touching the register
  task automatic drain_pipe;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // offer one item, keep valid high into a following burst
  task automatic send_item(input ctc_pkg::item_t v, input bit has_known,
                           input ctc_pkg::result_t known, input bit last_in_burst);
    item       <= v;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_results.push_back(has_known ? known : correct_track(v, gain_model));
    items_sent++;
    if (last_in_burst) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [ctc_pkg::CW-1:0] rand_coord;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return ctc_pkg::CW'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  function automatic ctc_pkg::item_t rand_item;
    ctc_pkg::item_t v;
    v.start_x = rand_coord();
    v.start_y = rand_coord();
    v.end_x   = rand_coord();
    v.end_y   = rand_coord();
    v.pos_x   = rand_coord();
    v.pos_y   = rand_coord();
    // zero-length segment now and then
    if ($urandom_range(0, 9) == 0) begin
      v.end_x = v.start_x;
      v.end_y = v.start_y;
    end
    // position right on the segment line
    if ($urandom_range(0, 19) == 0) begin
      v.pos_x = v.start_x;
      v.pos_y = v.start_y;
    end
    return v;
  endfunction

  // receiver stall pattern, overridden by a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= !hold_off && ($urandom_range(0, 3) != 0 || items_sent < 40);
    end
  end

  // long hold-off while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item %p", result);
        errors++;
      end else begin
        ctc_pkg::result_t e;
        e = pending_results.pop_front();
        results_seen++;
        if (result.degenerate) degen_seen++;
        if (result.foot_x !== e.foot_x) begin
          $error("foot_x exp %h got %h", e.foot_x, result.foot_x); errors++;
        end
        if (result.foot_y !== e.foot_y) begin
          $error("foot_y exp %h got %h", e.foot_y, result.foot_y); errors++;
        end
        if (result.deviation !== e.deviation) begin
          $error("deviation exp %h got %h", e.deviation, result.deviation); errors++;
        end
        if (result.target_x !== e.target_x) begin
          $error("target_x exp %h got %h", e.target_x, result.target_x); errors++;
        end
        if (result.target_y !== e.target_y) begin
          $error("target_y exp %h got %h", e.target_y, result.target_y); errors++;
        end
        if (result.degenerate !== e.degenerate) begin
          $error("degenerate exp %b got %b", e.degenerate, result.degenerate); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("cross_track_correction: mismatch");
        $finish;
      end
    end
  end

  typedef struct {
    ctc_pkg::item_t   it;
    bit               has_known;
    ctc_pkg::result_t known;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic ctc_pkg::item_t mk(input logic [ctc_pkg::CW-1:0] a, b, c, d, e, f);
    ctc_pkg::item_t v;
    v = {a, b, c, d, e, f};
    return v;
  endfunction

  initial begin
    logic [ctc_pkg::GW-1:0] gain_plan[4];
    ctc_pkg::result_t none;
    none = '0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item_valid = 1'b0; item = '0;
    gain_model = ctc_pkg::GAIN_RESET;
    items_sent = 0; results_seen = 0; degen_seen = 0; errors = 0; gains_used = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases at reset gain
    directed.push_back('{mk(0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 1'b1}});
    directed.push_back('{mk(0, 0, 0, 0, 32'h30000, 32'h40000), 1,
                         '{0, 0, 32'h50000, 0, 0, 1'b1}});
    directed.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000), 1,
                         '{32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                           32'h7fffffff, 32'h7fffffff, 1'b1}});
    directed.push_back('{mk(0, 0, 32'ha0000, 0, 32'h50000, 32'h20000), 0, none});
    directed.push_back('{mk(0, 0, 32'ha0000, 0, 32'h50000, 32'hfffe0000), 0, none});
    directed.push_back('{mk(0, 0, 32'ha0000, 32'ha0000, 32'h30000, 32'h30000), 0, none});
    directed.push_back('{mk(0, 0, 0, 32'ha0000, 32'h10000, 32'h50000), 0, none});
    directed.push_back('{mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h80000000), 0, none});
    directed.push_back('{mk(32'h80000000, 0, 32'h7fffffff, 0,
                            0, 32'h7fffffff), 0, none});
    directed.push_back('{mk(0, 32'h80000000, 0, 32'h7fffffff,
                            32'h80000000, 0), 0, none});
    directed.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7ffffffe, 32'h7fffffff,
                            32'h80000000, 32'h80000000), 0, none});
    directed.push_back('{mk(32'h1, 32'h1, 32'h2, 32'h1, 32'h1, 32'h2), 0, none});
    foreach (directed[i])
      send_item(directed[i].it, directed[i].has_known, directed[i].known,
                $urandom_range(0, 2) == 0);
    item_valid <= 1'b0;

    // random phases across gain settings, pipeline drained between them
    gain_plan[0] = 16'd0;
    gain_plan[1] = 16'hffff;
    gain_plan[2] = 16'd256;
    gain_plan[3] = ctc_pkg::GW'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      int burst;
      drain_pipe();
      if (ph > 0) write_gain(gain_plan[ph - 1]);
      if (ph == 0) write_gain(ctc_pkg::GAIN_RESET);
      burst = 0;
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        bit last;
        if (burst == 0) burst = $urandom_range(1, 20);
        burst--;
        last = (burst == 0) && ($urandom_range(0, 3) != 0);
        send_item(rand_item(), 0, none, last);
      end
      item_valid <= 1'b0;
    end

    // wind down
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d items, %0d results (%0d zero-length segments), %0d gain writes",
             items_sent, results_seen, degen_seen, gains_used);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("cross_track_correction: match");
    end else begin
      $display("cross_track_correction: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ctc_pkg.sv
rtl/core/ctc_div.sv
rtl/core/ctc_sqrt.sv
rtl/core/cross_track_correction.sv
rtl/core/ctc_checker.sv
dv/cross_track_correction_tb.sv
